// ===== hw/rtl/vntc_pkg.sv =====
// Shared types and constants for the value-noise terrain classifier.
package vntc_pkg;

    // Lattice hash multipliers
    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_M = 32'd1274126177;

    // Per-channel seed offsets
    localparam logic [31:0] SEED_OFS_MOIST  = 32'h0000_0011;
    localparam logic [31:0] SEED_OFS_DETAIL = 32'h0000_0022;

    // Cell size exponents
    localparam int unsigned SH_ELEV   = 3;
    localparam int unsigned SH_MOIST  = 4;
    localparam int unsigned SH_DETAIL = 2;

    // Register stages inside one noise channel
    localparam int unsigned CH_STAGES = 6;

    // Classification thresholds
    localparam logic signed [7:0] WATER_ELEV_MAX  = -8'sd45;
    localparam logic signed [7:0] WATER_MOIST_MAX = -8'sd20;
    localparam logic signed [7:0] ROCK_ELEV_MIN   = 8'sd55;
    localparam logic signed [7:0] DIRT_DETAIL_MAX = -8'sd55;
    localparam logic signed [7:0] DIRT_MOIST_MAX  = -8'sd25;
    localparam logic signed [7:0] DIRT_ELEV_MIN   = 8'sd10;

    typedef enum logic [1:0] {
        CLS_GRASS = 2'd0,
        CLS_DIRT  = 2'd1,
        CLS_WATER = 2'd2,
        CLS_ROCK  = 2'd3
    } terrain_t;

endpackage

// ===== hw/rtl/value_noise_terrain_classifier.sv =====
// Terrain classifier over three hashed bilinear value-noise channels.
// Throughput is one tile per clock while the output is not stalled.
// Each channel runs a six-stage pipeline
// (coordinate multiply, seed add, hash add and xor-shift, 24-bit hash
// multiply, x interpolation, y interpolation) and a final stage picks the
// terrain class. Every stage has its own valid bit and moves when the
// stage after it is empty or moving, so bubbles close up under back
// pressure. The seed is written on the cfg port, which is always ready;
// write it only while no tiles are in flight.
module value_noise_terrain_classifier #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [31:0]                             cfg_data,       // seed
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tile_x, tile_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // terrain_class[1:0], elevation[9:2], moisture[17:10], detail[25:18]
    output logic [31:0]                             m_axis_tdata
);

    localparam int unsigned NSTG = vntc_pkg::CH_STAGES + 1;

    // seed registers, offsets folded in at write time
    logic [31:0] seed_elev_reg, seed_moist_reg, seed_det_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_elev_reg  <= '0;
            seed_moist_reg <= vntc_pkg::SEED_OFS_MOIST;
            seed_det_reg   <= vntc_pkg::SEED_OFS_DETAIL;
        end else if (cfg_valid) begin
            seed_elev_reg  <= cfg_data;
            seed_moist_reg <= cfg_data + vntc_pkg::SEED_OFS_MOIST;
            seed_det_reg   <= cfg_data + vntc_pkg::SEED_OFS_DETAIL;
        end
    end

    // valid chain and per-stage enables
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];

    logic [COORD_BITS-1:0] tile_x, tile_y;

    assign tile_x = s_axis_tdata[COORD_BITS-1:0];
    assign tile_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    logic signed [7:0] elev, moist, det;

    vntc_channel #(.COORD_BITS(COORD_BITS), .SH(vntc_pkg::SH_ELEV)) u_elev (
        .aclk     (aclk),
        .stage_en (en[NSTG-2:0]),
        .tile_x   (tile_x),
        .tile_y   (tile_y),
        .seed     (seed_elev_reg),
        .noise    (elev)
    );

    vntc_channel #(.COORD_BITS(COORD_BITS), .SH(vntc_pkg::SH_MOIST)) u_moist (
        .aclk     (aclk),
        .stage_en (en[NSTG-2:0]),
        .tile_x   (tile_x),
        .tile_y   (tile_y),
        .seed     (seed_moist_reg),
        .noise    (moist)
    );

    vntc_channel #(.COORD_BITS(COORD_BITS), .SH(vntc_pkg::SH_DETAIL)) u_det (
        .aclk     (aclk),
        .stage_en (en[NSTG-2:0]),
        .tile_x   (tile_x),
        .tile_y   (tile_y),
        .seed     (seed_det_reg),
        .noise    (det)
    );

    // classification, priority water > rock > dirt > grass
    vntc_pkg::terrain_t cls_next;

    always_comb begin
        if (elev < vntc_pkg::WATER_ELEV_MAX && moist < vntc_pkg::WATER_MOIST_MAX) begin
            cls_next = vntc_pkg::CLS_WATER;
        end else if (elev > vntc_pkg::ROCK_ELEV_MIN) begin
            cls_next = vntc_pkg::CLS_ROCK;
        end else if (det < vntc_pkg::DIRT_DETAIL_MAX ||
                     (moist < vntc_pkg::DIRT_MOIST_MAX && elev > vntc_pkg::DIRT_ELEV_MIN)) begin
            cls_next = vntc_pkg::CLS_DIRT;
        end else begin
            cls_next = vntc_pkg::CLS_GRASS;
        end
    end

    logic [31:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            out_reg <= {6'd0, det, moist, elev, cls_next};
        end
    end

    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

endmodule

// ===== hw/rtl/vntc_channel.sv =====
// One bilinear hashed value-noise channel, six register stages.
module vntc_channel #(
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned SH         = 3
) (
    input  logic                                aclk,
    input  logic [vntc_pkg::CH_STAGES-1:0]      stage_en,
    input  logic [COORD_BITS-1:0]               tile_x,
    input  logic [COORD_BITS-1:0]               tile_y,
    input  logic [31:0]                         seed,
    output logic signed [7:0]                   noise
);

    typedef logic [SH-1:0] frac_t;

    // floor(a + (b - a) * f / 2^SH)
    function automatic logic signed [7:0] lerp(input logic signed [7:0] a,
                                               input logic signed [7:0] b,
                                               input frac_t f);
        logic signed [8:0]  d;
        logic signed [13:0] p;
        logic signed [13:0] q;
        logic signed [8:0]  r;
        d = 9'(b) - 9'(a);
        p = 14'(d) * $signed(14'({1'b0, f}));
        q = p >>> SH;
        r = 9'(a) + q[8:0];
        return r[7:0];
    endfunction

    // stage 1: coordinate products
    logic [31:0] cx32, cy32;
    logic [31:0] px_reg, py_reg;
    frac_t       fx1_reg, fy1_reg;

    assign cx32 = 32'(tile_x >> SH);
    assign cy32 = 32'(tile_y >> SH);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            px_reg  <= cx32 * vntc_pkg::HASH_MUL_X;
            py_reg  <= cy32 * vntc_pkg::HASH_MUL_Y;
            fx1_reg <= tile_x[SH-1:0];
            fy1_reg <= tile_y[SH-1:0];
        end
    end

    // stage 2: neighbor cell offsets and seed
    logic [31:0] ax0_reg, ax1_reg, ay0_reg, ay1_reg;
    frac_t       fx2_reg, fy2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            ax0_reg <= px_reg + seed;
            ax1_reg <= px_reg + vntc_pkg::HASH_MUL_X + seed;
            ay0_reg <= py_reg;
            ay1_reg <= py_reg + vntc_pkg::HASH_MUL_Y;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
    end

    // stage 3: hash sum and first xor-shift; corners a, b, c, d
    logic [31:0] h    [4];
    logic [31:0] g_reg[4];
    frac_t       fx3_reg, fy3_reg;

    assign h[0] = ax0_reg + ay0_reg;
    assign h[1] = ax1_reg + ay0_reg;
    assign h[2] = ax0_reg + ay1_reg;
    assign h[3] = ax1_reg + ay1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int i = 0; i < 4; i++) begin
                g_reg[i] <= h[i] ^ (h[i] >> 13);
            end
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
    end

    // stage 4: final multiply; only the low 24 bits feed the corner byte
    logic [23:0]       m     [4];
    logic signed [7:0] cv_reg[4];
    frac_t             fx4_reg, fy4_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m[i] = g_reg[i][23:0] * vntc_pkg::HASH_MUL_M[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            for (int i = 0; i < 4; i++) begin
                // low byte minus 128 is the byte with its top bit flipped
                cv_reg[i] <= $signed(m[i][7:0] ^ m[i][23:16] ^ 8'h80);
            end
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
        end
    end

    // stage 5: interpolate along x
    logic signed [7:0] top_reg, bot_reg;
    frac_t             fy5_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            top_reg <= lerp(cv_reg[0], cv_reg[1], fx4_reg);
            bot_reg <= lerp(cv_reg[2], cv_reg[3], fx4_reg);
            fy5_reg <= fy4_reg;
        end
    end

    // stage 6: interpolate along y
    logic signed [7:0] noise_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            noise_reg <= lerp(top_reg, bot_reg, fy5_reg);
        end
    end

    assign noise = noise_reg;

endmodule

// ===== hw/rtl/vntc_checker.sv =====
// Port-level checks for the terrain classifier, bound to the top level.
module vntc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [31:0]                        m_axis_tdata
);

    logic signed [7:0] elev;
    assign elev = $signed(m_axis_tdata[9:2]);

    // output register empties after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");

    // an empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_water_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == vntc_pkg::CLS_WATER
        |-> elev < vntc_pkg::WATER_ELEV_MAX)
        else $error("water with high elevation");

    a_rock_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == vntc_pkg::CLS_ROCK
        |-> elev > vntc_pkg::ROCK_ELEV_MIN)
        else $error("rock with low elevation");

endmodule

bind value_noise_terrain_classifier vntc_checker u_vntc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/value_noise_terrain_classifier_tb.sv =====
// Self-checking testbench for value_noise_terrain_classifier, with its own terrain predictor.
module value_noise_terrain_classifier_tb;

    localparam int HALF_PERIOD  = 4;
    localparam int PIPE_LATENCY = 7;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [31:0] MIX_X = 32'd374761393;
    localparam logic [31:0] MIX_Y = 32'd668265263;
    localparam logic [31:0] MIX_M = 32'd1274126177;
    localparam logic [31:0] MOIST_SEED_OFS  = 32'h11;
    localparam logic [31:0] DETAIL_SEED_OFS = 32'h22;
    localparam int ELEV_SHIFT   = 3;
    localparam int MOIST_SHIFT  = 4;
    localparam int DETAIL_SHIFT = 2;

    typedef struct packed {
        vntc_pkg::terrain_t cls;
        logic signed [7:0]  elev;
        logic signed [7:0]  moist;
        logic signed [7:0]  det;
    } tile_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // tile_x[9:0], tile_y[19:10], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // terrain_class[1:0], elevation[9:2], moisture[17:10], detail[25:18]
    logic [31:0] m_axis_tdata;

    tile_result_t tile_results_due[$];
    logic [31:0]  cur_seed = '0;
    int           errors = 0;
    int           tiles_sent = 0;
    int           tiles_checked = 0;
    int           seeds_written = 0;
    int           class_hits[4] = '{0, 0, 0, 0};
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           hold_request = 0;
    int           quiet_cycles = 0;

    value_noise_terrain_classifier #(.COORD_BITS(10)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic logic [31:0] lattice_mix(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] s);
        logic [31:0] h;
        h = cx * MIX_X + cy * MIX_Y + s;
        h = (h ^ (h >> 13)) * MIX_M;
        return h ^ (h >> 16);
    endfunction

    function automatic int corner_height(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
        logic [31:0] h;
        h = lattice_mix(cx, cy, s);
        return int'({24'd0, h[7:0]}) - 128;
    endfunction

    // floored d*f / 2^sh
    function automatic int blend_step(int d, int f, int sh);
        return (d * f) >>> sh;
    endfunction

    function automatic int channel_noise(logic [9:0] x, logic [9:0] y, int sh, logic [31:0] s);
        logic [31:0] cx, cy;
        int fx, fy, a, b, c, d, top, bot;
        cx = {22'd0, x} >> sh;
        cy = {22'd0, y} >> sh;
        fx = int'({22'd0, x}) & ((1 << sh) - 1);
        fy = int'({22'd0, y}) & ((1 << sh) - 1);
        a = corner_height(cx, cy, s);
        b = corner_height(cx + 32'd1, cy, s);
        c = corner_height(cx, cy + 32'd1, s);
        d = corner_height(cx + 32'd1, cy + 32'd1, s);
        top = a + blend_step(b - a, fx, sh);
        bot = c + blend_step(d - c, fx, sh);
        return top + blend_step(bot - top, fy, sh);
    endfunction

    function automatic tile_result_t classify_tile(logic [9:0] x, logic [9:0] y,
                                                   logic [31:0] s);
        int e, m, d;
        tile_result_t r;
        e = channel_noise(x, y, ELEV_SHIFT, s);
        m = channel_noise(x, y, MOIST_SHIFT, s + MOIST_SEED_OFS);
        d = channel_noise(x, y, DETAIL_SHIFT, s + DETAIL_SEED_OFS);
        if (e < -45 && m < -20)
            r.cls = vntc_pkg::CLS_WATER;
        else if (e > 55)
            r.cls = vntc_pkg::CLS_ROCK;
        else if (d < -55 || (m < -25 && e > 10))
            r.cls = vntc_pkg::CLS_DIRT;
        else
            r.cls = vntc_pkg::CLS_GRASS;
        r.elev  = e[7:0];
        r.moist = m[7:0];
        r.det   = d[7:0];
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        tile_result_t want;
        logic [1:0]        got_cls;
        logic signed [7:0] got_elev, got_moist, got_det;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_cls   = m_axis_tdata[1:0];
            got_elev  = m_axis_tdata[9:2];
            got_moist = m_axis_tdata[17:10];
            got_det   = m_axis_tdata[25:18];
            if (tile_results_due.size() == 0) begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = tile_results_due.pop_front();
                tiles_checked++;
                class_hits[want.cls]++;
                if (got_cls !== want.cls) begin
                    $error("terrain_class: expected %0d, got %0d", want.cls, got_cls);
                    errors++;
                end
                if (got_elev !== want.elev) begin
                    $error("elevation: expected %0d, got %0d", want.elev, got_elev);
                    errors++;
                end
                if (got_moist !== want.moist) begin
                    $error("moisture: expected %0d, got %0d", want.moist, got_moist);
                    errors++;
                end
                if (got_det !== want.det) begin
                    $error("detail: expected %0d, got %0d", want.det, got_det);
                    errors++;
                end
            end
        end
    end

    // ---------------- receiver ready ----------------
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("value_noise_terrain_classifier_tb NOT OK");
            $finish;
        end
    end

    // ---------------- shared tasks ----------------
    // valid stays high across back-to-back items; it drops on a random gap or when drain_pipeline ends the stream
    task automatic send_tile(input logic [9:0] x, input logic [9:0] y);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, y, x};
        do @(posedge aclk); while (!s_axis_tready);
        tile_results_due.push_back(classify_tile(x, y, cur_seed));
        tiles_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (tile_results_due.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        drain_pipeline();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cur_seed = value;
        seeds_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] random_coord();
        logic [9:0] c;
        c = 10'($urandom);
        case ($urandom_range(9))
            0: c[3:0] = 4'h0;                         // on a cell corner
            1: c[3:0] = 4'hF;                         // last step before the next cell
            2: c = 10'(1023 - $urandom_range(15));    // last cells, neighbor past the edge
            default: ;
        endcase
        return c;
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_seed_corners();
        logic [9:0] xs[14] = '{0, 1023, 1023, 0, 3, 4, 7, 8, 15, 16, 1016, 1012, 511, 682};
        logic [9:0] ys[14] = '{0, 1023, 0, 1023, 4, 3, 8, 7, 16, 15, 1020, 1008, 512, 341};
        src_idle_pct = 0;
        sink_stall_pct = 0;
        foreach (xs[i]) send_tile(xs[i], ys[i]);
    endtask

    // seed offsets that wrap past 2^32, plus the extremes
    task automatic test_seed_wrap();
        logic [31:0] seeds[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFEF, 32'hFFFF_FFDE, 32'h8000_0000};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_tile(10'd0, 10'd0);
            send_tile(10'd1023, 10'd1023);
            send_tile(random_coord(), random_coord());
        end
    endtask

    task automatic test_output_backpressure();
        write_seed($urandom);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_tile(random_coord(), random_coord());
    endtask

    task automatic test_random_tiles();
        int src_pct[4]  = '{0, 82, 0, 7};
        int sink_pct[4] = '{0, 0, 82, 7};
        foreach (src_pct[p]) begin
            write_seed(p == 0 ? 32'd0 : $urandom);
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            repeat (PHASE_ITEMS) send_tile(random_coord(), random_coord());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_seed_corners();
        test_seed_wrap();
        test_output_backpressure();
        test_random_tiles();
        drain_pipeline();

        $display("%0d tiles sent, %0d results checked, %0d seed writes incl. wrap cases",
                 tiles_sent, tiles_checked, seeds_written);
        $display("classes seen: grass %0d, dirt %0d, water %0d, rock %0d",
                 class_hits[vntc_pkg::CLS_GRASS], class_hits[vntc_pkg::CLS_DIRT],
                 class_hits[vntc_pkg::CLS_WATER], class_hits[vntc_pkg::CLS_ROCK]);
        if (errors == 0)
            $display("value_noise_terrain_classifier_tb OK");
        else
            $display("value_noise_terrain_classifier_tb NOT OK");
        $finish;
    end

endmodule
